### rtl/core/dsct_pkg.sv
// Shared constants, types and functions for the degree sine/cosine/tangent core.
package dsct_pkg;

	localparam int CordicStages = 16;
	localparam int StW = (CordicStages > 1) ? $clog2(CordicStages) : 1;
	localparam int TurnUnits = 92160;
	localparam int QuarterUnits = 23040;
	localparam logic [26:0] RadMul = 27'd74961321;
	localparam logic [24:0] ZMul = 25'd18740330;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam logic [18:0] RadLimit = 19'd524287;
	localparam int QueueDepth = 4;
	localparam int QPtrW = $clog2(QueueDepth);

	// Width of the tangent quotient: up to 31+16 bit dividend.
	localparam int NumW = 48;
	localparam int DenW = 32;
	localparam int QuoW = 48;

	typedef logic [1:0] quad_t;

	// Item passed from the front part to the back part.
	typedef struct packed {
		logic signed [19:0] rad;
		quad_t               quad;
		logic signed [33:0]  z;
	} front_item_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
		logic signed [33:0] v;
		case (idx)
			5'd0: v = 34'sd843314857;
			5'd1: v = 34'sd497837829;
			5'd2: v = 34'sd263043837;
			5'd3: v = 34'sd133525159;
			5'd4: v = 34'sd67021687;
			5'd5: v = 34'sd33543516;
			5'd6: v = 34'sd16775851;
			5'd7: v = 34'sd8388437;
			5'd8: v = 34'sd4194283;
			5'd9: v = 34'sd2097149;
			5'd10: v = 34'sd1048576;
			5'd11: v = 34'sd524288;
			5'd12: v = 34'sd262144;
			5'd13: v = 34'sd131072;
			5'd14: v = 34'sd65536;
			5'd15: v = 34'sd32768;
			5'd16: v = 34'sd16384;
			5'd17: v = 34'sd8192;
			5'd18: v = 34'sd4096;
			5'd19: v = 34'sd2048;
			5'd20: v = 34'sd1024;
			5'd21: v = 34'sd512;
			5'd22: v = 34'sd256;
			5'd23: v = 34'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Round a Q1.30 value to Q1.15 and saturate.
	function automatic logic signed [15:0] sat_q15(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = (v + 34'sd16384) >>> 15;
		if (r > 34'sd32767) return 16'sd32767;
		if (r < -34'sd32768) return -16'sd32768;
		return r[15:0];
	endfunction

endpackage

### rtl/core/dsct_front.sv
// Front part: converts to radians and reduces the angle into one quadrant.
module dsct_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [17:0]         angle_deg,
	output logic                       out_valid,
	input  logic                       out_ready,
	output dsct_pkg::front_item_t      out_item
);
	import dsct_pkg::*;

	logic               v_s1, v_s2, v_s3;
	logic               adv;
	logic signed [17:0] a_s1;
	logic [17:0]        mag_s1;
	logic [43:0]        prod_s2;
	logic               neg_s2, neg_s3;
	logic [17:0]        m_comb;
	logic [16:0]        m_s2;
	logic [14:0]        r_comb;
	quad_t              quad_comb, quad_s3;
	logic [18:0]        rq_comb;
	logic signed [19:0] rad_s3;
	logic [39:0]        zp_s3;
	logic [14:0]        r_s3;
	logic [19:0]        rad_mag;

	// Whole front pipeline moves together when its last stage can leave.
	assign adv = !v_s3 || out_ready;
	assign in_ready = adv;

	// Reduce modulo one turn; the input spans less than one and a half turns each way.
	always_comb begin
		if (a_s1 < 0) begin
			if (-$signed({a_s1[17], a_s1}) > 19'sd92160)
				m_comb = 18'(19'($signed({a_s1[17], a_s1}) + 19'sd184320));
			else if (-$signed({a_s1[17], a_s1}) == 19'sd92160)
				m_comb = '0;
			else
				m_comb = 18'(19'($signed({a_s1[17], a_s1}) + 19'sd92160));
		end else if (a_s1 >= 18'sd92160) begin
			m_comb = 18'(a_s1 - 18'sd92160);
		end else begin
			m_comb = 18'(a_s1);
		end
	end

	always_comb begin
		if (m_s2 >= 17'd69120) begin
			quad_comb = 2'd3; r_comb = 15'(m_s2 - 17'd69120);
		end else if (m_s2 >= 17'd46080) begin
			quad_comb = 2'd2; r_comb = 15'(m_s2 - 17'd46080);
		end else if (m_s2 >= 17'd23040) begin
			quad_comb = 2'd1; r_comb = 15'(m_s2 - 17'd23040);
		end else begin
			quad_comb = 2'd0; r_comb = m_s2[14:0];
		end
	end

	assign rad_mag = 20'((prod_s2 + 44'd8388608) >> 24);
	assign rq_comb = (rad_mag > {1'b0, RadLimit}) ? RadLimit : rad_mag[18:0];

	// Three stages: capture, multiply and reduce, quadrant split.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= angle_deg;
			mag_s1  <= angle_deg[17] ? 18'(-angle_deg) : 18'(angle_deg);
			prod_s2 <= 44'(mag_s1) * 44'(RadMul);
			neg_s2  <= a_s1[17];
			m_s2    <= m_comb[16:0];
			neg_s3  <= neg_s2;
			rad_s3  <= neg_s2 ? -$signed({1'b0, rq_comb}) : $signed({1'b0, rq_comb});
			quad_s3 <= quad_comb;
			r_s3    <= r_comb;
		end
	end

	assign zp_s3 = 40'(r_s3) * 40'(ZMul) + 40'd128;
	assign out_valid = v_s3;
	assign out_item.rad  = rad_s3;
	assign out_item.quad = quad_s3;
	assign out_item.z    = $signed({2'b00, zp_s3[39:8]});

	logic unused_neg;
	assign unused_neg = neg_s3;
endmodule

### rtl/core/dsct_queue.sv
// Short queue of front items between the front and back parts.
module dsct_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  dsct_pkg::front_item_t in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dsct_pkg::front_item_t out_item
);
	import dsct_pkg::*;

	front_item_t        mem_q [QueueDepth];
	logic [QPtrW-1:0]   wp_q, rp_q;
	logic [QPtrW:0]     cnt_q;
	logic               wr, rd;

	assign in_ready  = cnt_q != (QPtrW+1)'(QueueDepth);
	assign out_valid = cnt_q != '0;
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;
	assign out_item = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_item;
	end
endmodule

### rtl/core/dsct_cordic.sv
// Pipelined CORDIC rotation with quadrant mapping to Q1.30 sine and cosine.
module dsct_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  dsct_pkg::front_item_t in_item,
	output logic                  out_valid,
	output logic signed [19:0]    rad,
	output logic signed [33:0]    s30,
	output logic signed [33:0]    c30
);
	import dsct_pkg::*;

	logic               v_s  [CordicStages+1];
	logic signed [33:0] x_s  [CordicStages+1];
	logic signed [33:0] y_s  [CordicStages+1];
	logic signed [33:0] z_s  [CordicStages+1];
	quad_t              q_s  [CordicStages+1];
	logic signed [19:0] r_s  [CordicStages+1];
	logic               vo_q;
	logic signed [19:0] rad_q;
	logic signed [33:0] s_q, c_q;

	assign v_s[0] = in_valid;
	assign x_s[0] = CordicGain;
	assign y_s[0] = '0;
	assign z_s[0] = in_item.z;
	assign q_s[0] = in_item.quad;
	assign r_s[0] = in_item.rad;

	// One registered micro-rotation per stage.
	for (genvar i = 0; i < CordicStages; i++) begin : g_stage
		logic               vr_q;
		logic signed [33:0] xr_q, yr_q, zr_q;
		quad_t              qr_q;
		logic signed [19:0] rr_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vr_q <= 1'b0;
			else if (adv) vr_q <= v_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_s[i][33]) begin
					xr_q <= x_s[i] - (y_s[i] >>> i);
					yr_q <= y_s[i] + (x_s[i] >>> i);
					zr_q <= z_s[i] - atan_q30(5'(i));
				end else begin
					xr_q <= x_s[i] + (y_s[i] >>> i);
					yr_q <= y_s[i] - (x_s[i] >>> i);
					zr_q <= z_s[i] + atan_q30(5'(i));
				end
				qr_q <= q_s[i];
				rr_q <= r_s[i];
			end
		end
		assign v_s[i+1] = vr_q;
		assign x_s[i+1] = xr_q;
		assign y_s[i+1] = yr_q;
		assign z_s[i+1] = zr_q;
		assign q_s[i+1] = qr_q;
		assign r_s[i+1] = rr_q;
	end

	// Quadrant symmetry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vo_q <= 1'b0;
		else if (adv) vo_q <= v_s[CordicStages];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_q <= r_s[CordicStages];
			case (q_s[CordicStages])
				2'd0: begin s_q <= y_s[CordicStages];  c_q <= x_s[CordicStages];  end
				2'd1: begin s_q <= x_s[CordicStages];  c_q <= -y_s[CordicStages]; end
				2'd2: begin s_q <= -y_s[CordicStages]; c_q <= -x_s[CordicStages]; end
				default: begin s_q <= -x_s[CordicStages]; c_q <= y_s[CordicStages]; end
			endcase
		end
	end

	logic unused_z;
	assign unused_z = ^z_s[CordicStages];
	assign out_valid = vo_q;
	assign rad = rad_q;
	assign s30 = s_q;
	assign c30 = c_q;
endmodule

### rtl/core/dsct_div.sv
// Pipelined restoring divider for the tangent, one quotient bit per stage.
module dsct_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  logic signed [19:0]     rad,
	input  logic signed [33:0]     s30,
	input  logic signed [33:0]     c30,
	output logic                   out_valid,
	output logic signed [19:0]     angle_rad,
	output logic signed [15:0]     sine_value,
	output logic signed [15:0]     cosine_value,
	output logic signed [31:0]     tangent_value,
	output logic                   tan_overflow
);
	import dsct_pkg::*;

	logic               v_s  [QuoW+1];
	logic [NumW-1:0]    n_s  [QuoW+1];
	logic [DenW:0]      rem_s[QuoW+1];
	logic [DenW-1:0]    d_s  [QuoW+1];
	logic [QuoW-1:0]    qt_s [QuoW+1];
	logic               ng_s [QuoW+1];
	logic               sp_s [QuoW+1];
	logic               cz_s [QuoW+1];
	logic signed [19:0] r_s  [QuoW+1];
	logic signed [15:0] sq_s [QuoW+1];
	logic signed [15:0] cq_s [QuoW+1];
	logic [33:0]        sa, ca;
	logic               vo_q, ov_q;
	logic signed [19:0] rad_q;
	logic signed [15:0] sqo_q, cqo_q;
	logic signed [31:0] tan_q;
	logic [QuoW-1:0]    qf;
	logic [31:0]        lim;

	assign sa = s30[33] ? 34'(-s30) : 34'(s30);
	assign ca = c30[33] ? 34'(-c30) : 34'(c30);
	assign v_s[0]   = in_valid;
	assign n_s[0]   = NumW'(sa) << 16;
	assign rem_s[0] = '0;
	assign d_s[0]   = ca[DenW-1:0];
	assign qt_s[0]  = '0;
	assign ng_s[0]  = s30[33] != c30[33];
	assign sp_s[0]  = !s30[33];
	assign cz_s[0]  = c30 == '0;
	assign r_s[0]   = rad;
	assign sq_s[0]  = sat_q15(s30);
	assign cq_s[0]  = sat_q15(c30);

	for (genvar i = 0; i < QuoW; i++) begin : g_bit
		logic [DenW+1:0] t;
		logic            vr_q;
		logic [NumW-1:0] nr_q;
		logic [DenW:0]   rr_q;
		logic [DenW-1:0] dr_q;
		logic [QuoW-1:0] qr_q;
		logic            ngr_q, spr_q, czr_q;
		logic signed [19:0] rdr_q;
		logic signed [15:0] sqr_q, cqr_q;
		assign t = {rem_s[i], n_s[i][NumW-1]} - {2'b00, d_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vr_q <= 1'b0;
			else if (adv) vr_q <= v_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				nr_q <= n_s[i] << 1;
				if (!t[DenW+1]) begin
					rr_q <= t[DenW:0];
					qr_q <= {qt_s[i][QuoW-2:0], 1'b1};
				end else begin
					rr_q <= {rem_s[i][DenW-1:0], n_s[i][NumW-1]};
					qr_q <= {qt_s[i][QuoW-2:0], 1'b0};
				end
				dr_q <= d_s[i]; ngr_q <= ng_s[i]; spr_q <= sp_s[i];
				czr_q <= cz_s[i]; rdr_q <= r_s[i];
				sqr_q <= sq_s[i]; cqr_q <= cq_s[i];
			end
		end
		assign v_s[i+1] = vr_q;   assign n_s[i+1] = nr_q;
		assign rem_s[i+1] = rr_q; assign d_s[i+1] = dr_q;
		assign qt_s[i+1] = qr_q;  assign ng_s[i+1] = ngr_q;
		assign sp_s[i+1] = spr_q; assign cz_s[i+1] = czr_q;
		assign r_s[i+1] = rdr_q;  assign sq_s[i+1] = sqr_q;
		assign cq_s[i+1] = cqr_q;
	end

	// Sign, saturation and overflow flag.
	assign qf  = qt_s[QuoW];
	assign lim = ng_s[QuoW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vo_q <= 1'b0;
		else if (adv) vo_q <= v_s[QuoW];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_q <= r_s[QuoW];
			sqo_q <= sq_s[QuoW];
			cqo_q <= cq_s[QuoW];
			if (cz_s[QuoW]) begin
				ov_q  <= 1'b1;
				tan_q <= sp_s[QuoW] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			end else if (qf > QuoW'(lim)) begin
				ov_q  <= 1'b1;
				tan_q <= ng_s[QuoW] ? $signed(32'(-lim)) : $signed(lim);
			end else begin
				ov_q  <= 1'b0;
				tan_q <= ng_s[QuoW] ? $signed(32'(-qf[31:0])) : $signed(qf[31:0]);
			end
		end
	end

	logic unused_n;
	assign unused_n = ^{n_s[QuoW], rem_s[QuoW], d_s[QuoW], sa[33:32], ca[33:32]};
	assign out_valid     = vo_q;
	assign angle_rad     = rad_q;
	assign sine_value    = sqo_q;
	assign cosine_value  = cqo_q;
	assign tangent_value = tan_q;
	assign tan_overflow  = ov_q;
endmodule

### rtl/core/degree_sine_cosine_tangent_core.sv
// Path: the front stages, the queue's storage registers, the CORDIC stages and
// the quadrant mapping register, then the divider stages and the result register.
// Throughput: one word per clock; the back pipeline stalls as a whole on
// m_axis_tready and the four-entry queue absorbs the front's words.
// Reset: arst_n clears all valid flags and the queue pointers and count at once; data registers are not reset.
module degree_sine_cosine_tangent_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [17:0] angle_deg
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata   // angle_rad, sine, cosine, tangent, tan_overflow
);
	import dsct_pkg::*;

	front_item_t        f_item, q_item;
	logic               f_valid, f_ready, q_valid, q_ready, adv;
	logic               c_valid, d_valid;
	logic signed [19:0] c_rad, o_rad;
	logic signed [33:0] c_s, c_c;
	logic signed [15:0] o_sin, o_cos;
	logic signed [31:0] o_tan;
	logic               o_ovf;

	dsct_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.angle_deg($signed(s_axis_tdata[17:0])),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	dsct_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	// Back pipeline advances when the output word is free or being taken.
	assign adv = !d_valid || m_axis_tready;
	assign q_ready = adv;

	dsct_cordic u_cordic (
		.clk, .arst_n, .adv,
		.in_valid(q_valid), .in_item(q_item),
		.out_valid(c_valid), .rad(c_rad), .s30(c_s), .c30(c_c)
	);

	dsct_div u_div (
		.clk, .arst_n, .adv,
		.in_valid(c_valid), .rad(c_rad), .s30(c_s), .c30(c_c),
		.out_valid(d_valid), .angle_rad(o_rad), .sine_value(o_sin),
		.cosine_value(o_cos), .tangent_value(o_tan), .tan_overflow(o_ovf)
	);

	assign m_axis_tvalid = d_valid;
	assign m_axis_tdata = {3'b000, o_ovf, o_tan, o_cos, o_sin, o_rad};

	logic unused_in;
	assign unused_in = ^s_axis_tdata[23:18];
endmodule
